>>> rtl/token_atom_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// Token atom stream decoder: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TOKEN_ATOM_STREAM_DECODER_DEFINES_SVH
`define TOKEN_ATOM_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset
`define TASD_ASSERT(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("tasd check failed");

// Antecedent implies consequent in the same cycle
`define TASD_ASSERT_IMPLY(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("tasd check failed");

`else

`define TASD_ASSERT(name, clock, reset, prop)
`define TASD_ASSERT_IMPLY(name, clock, reset, ante, cons)

`endif

`endif

>>> rtl/tasd_pkg.sv
// ----------------------------------------------------------------------------
// Token atom stream decoder package
// Payload types and fixed codes shared by the channels and the decoder.
// ----------------------------------------------------------------------------
package tasd_pkg;

  // Byte roles
  localparam logic [2:0] ROLE_TINY    = 3'd0;
  localparam logic [2:0] ROLE_HEADER  = 3'd1;
  localparam logic [2:0] ROLE_LEN     = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_CTRL    = 3'd4;

  // Atom kinds
  localparam logic [2:0] KIND_TINY   = 3'd0;
  localparam logic [2:0] KIND_SHORT  = 3'd1;
  localparam logic [2:0] KIND_MEDIUM = 3'd2;
  localparam logic [2:0] KIND_LONG   = 3'd3;
  localparam logic [2:0] KIND_CTRL   = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_INT_LONG  = 2'd1;
  localparam logic [1:0] STAT_OVER      = 2'd2;
  localparam logic [1:0] STAT_CONTINUED = 2'd3;

  // Header prefix masks and match patterns
  localparam logic [7:0] HDR_TINY_MASK  = 8'b1000_0000;
  localparam logic [7:0] HDR_SHORT_MASK = 8'b1100_0000;
  localparam logic [7:0] HDR_SHORT_PAT  = 8'b1000_0000;
  localparam logic [7:0] HDR_MED_MASK   = 8'b1110_0000;
  localparam logic [7:0] HDR_MED_PAT    = 8'b1100_0000;
  localparam logic [7:0] HDR_LONG_MASK  = 8'b1111_0000;
  localparam logic [7:0] HDR_LONG_PAT   = 8'b1110_0000;

  // Largest integer payload, in bytes
  localparam logic [23:0] INT_MAX_BYTES = 24'd8;

  // Reset value of the byte-atom limit
  localparam logic [23:0] BYTES_LIMIT_RESET = 24'd2048;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [2:0]  atom_kind;
    logic        is_bytes;
    logic        is_signed;
    logic [23:0] atom_length;
    logic [7:0]  byte_out;
    logic [63:0] int_value;
    logic        atom_end;
    logic [1:0]  status;
  } out_item_t;

endpackage

>>> rtl/tasd_in_if.sv
// ----------------------------------------------------------------------------
// Token atom stream decoder input channel
// Valid/ready channel carrying one stream byte and its restart flag.
// ----------------------------------------------------------------------------
interface tasd_in_if import tasd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tasd_out_if.sv
// ----------------------------------------------------------------------------
// Token atom stream decoder output channel
// Valid/ready channel carrying the decode result of one stream byte.
// ----------------------------------------------------------------------------
interface tasd_out_if import tasd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/token_atom_stream_decoder.sv
// ----------------------------------------------------------------------------
// Token atom stream decoder
// Classifies each byte of a storage security token stream and tracks atoms.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       word contents
//  --------  ----  --------------  -----------------------------------------
//  in_ch     in    valid/ready     data_byte, restart
//  out_ch    out   valid/ready     role, kind, flags, length, byte, value,
//                                  atom_end, status
//  cfg       in    cfg_we          cfg_data -> bytes_limit (24 bits)
//
//  One word per cycle sustained while out_ch.ready stays high; the result word
//  is registered: the input register feeds the decode stage, which writes the
//  result register. The per-byte state update is the only loop. Synchronous
//  reset clears the atom state and the valid flags and sets bytes_limit to
//  2048. An output stall holds the result register and then the input
//  register; in_ch.ready drops only when both are full.
//
`include "token_atom_stream_decoder_defines.svh"

module token_atom_stream_decoder import tasd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tasd_in_if.sink     in_ch,
  tasd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data
);

  // Decode phase codes
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // Configuration
  logic [23:0] bytes_limit;

  // Input register
  logic     in_valid;
  in_item_t in_item;

  // Result register
  logic      res_valid;
  out_item_t res;

  // Atom state
  logic [1:0]  phase;
  logic [1:0]  length_bytes_left;
  logic [23:0] payload_left;
  logic [23:0] length_latched;
  logic [2:0]  kind_latched;
  logic [1:0]  flags_latched;   // bit1 byte string, bit0 sign/continued
  logic [63:0] value_accum;
  logic [1:0]  status_latched;

  logic [1:0]  phase_next;
  logic [1:0]  length_bytes_left_next;
  logic [23:0] payload_left_next;
  logic [23:0] length_latched_next;
  logic [2:0]  kind_latched_next;
  logic [1:0]  flags_latched_next;
  logic [63:0] value_accum_next;
  logic [1:0]  status_latched_next;
  out_item_t   res_next;

  logic res_free;
  logic advance;

  // Result register frees when empty or being taken this cycle
  assign res_free     = !res_valid || out_ch.ready;
  assign advance      = in_valid && res_free;
  assign in_ch.ready  = !in_valid || res_free;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;

  // Status once the length is known
  function automatic logic [1:0] hdr_status(input logic [1:0]  flags,
                                            input logic [23:0] len,
                                            input logic [23:0] limit);
    logic [1:0] st;
    if (flags[1]) begin
      if (flags[0]) begin
        st = STAT_CONTINUED;
      end else if (len > limit) begin
        st = STAT_OVER;
      end else begin
        st = STAT_OK;
      end
    end else begin
      st = (len > INT_MAX_BYTES) ? STAT_INT_LONG : STAT_OK;
    end
    return st;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [1:0] ph;
    logic [2:0] role;
    logic       atom_end;
    logic       hdr_done;
    logic [1:0] lbl_dec;
    logic [23:0] pl_dec;

    b        = in_item.data_byte;
    // Restart or an unused phase code: treat this byte as a header
    ph       = (in_item.restart || phase > PH_PAYLOAD) ? PH_HEADER : phase;
    role     = ROLE_TINY;
    atom_end = 1'b0;
    hdr_done = 1'b0;
    lbl_dec  = 2'd0;
    pl_dec   = 24'd0;

    phase_next             = ph;
    length_bytes_left_next = length_bytes_left;
    payload_left_next      = payload_left;
    length_latched_next    = length_latched;
    kind_latched_next      = kind_latched;
    flags_latched_next     = flags_latched;
    value_accum_next       = value_accum;
    status_latched_next    = status_latched;

    unique case (ph)
      PH_LEN: begin
        role                = ROLE_LEN;
        // Shift in the next big-endian length byte
        length_latched_next = {length_latched[15:0], b};
        lbl_dec = (length_bytes_left == 2'd0) ? 2'd0 : length_bytes_left - 2'd1;
        length_bytes_left_next = lbl_dec;
        hdr_done = (lbl_dec == 2'd0);
      end
      PH_PAYLOAD: begin
        role   = ROLE_PAYLOAD;
        pl_dec = (payload_left == 24'd0) ? 24'd0 : payload_left - 24'd1;
        payload_left_next = pl_dec;
        // Gather integers big-endian; low 64 bits survive an overlong one
        if (!flags_latched[1]) begin
          value_accum_next = {value_accum[55:0], b};
        end
        if (pl_dec == 24'd0) begin
          atom_end   = 1'b1;
          phase_next = PH_HEADER;
        end
      end
      default: begin
        // Header byte: drop whatever the previous atom left behind
        value_accum_next       = 64'd0;
        status_latched_next    = STAT_OK;
        length_latched_next    = 24'd0;
        length_bytes_left_next = 2'd0;
        payload_left_next      = 24'd0;
        if ((b & HDR_TINY_MASK) == 8'd0) begin
          kind_latched_next  = KIND_TINY;
          flags_latched_next = {1'b0, b[6]};
          value_accum_next   = {58'd0, b[5:0]};
          role               = ROLE_TINY;
          atom_end           = 1'b1;
        end else if ((b & HDR_SHORT_MASK) == HDR_SHORT_PAT) begin
          kind_latched_next   = KIND_SHORT;
          flags_latched_next  = {b[5], b[4]};
          length_latched_next = {20'd0, b[3:0]};
          role                = ROLE_HEADER;
          hdr_done            = 1'b1;
        end else if ((b & HDR_MED_MASK) == HDR_MED_PAT) begin
          kind_latched_next      = KIND_MEDIUM;
          flags_latched_next     = {b[4], b[3]};
          length_latched_next    = {21'd0, b[2:0]};
          length_bytes_left_next = 2'd1;
          phase_next             = PH_LEN;
          role                   = ROLE_HEADER;
        end else if ((b & HDR_LONG_MASK) == HDR_LONG_PAT) begin
          // Reserved bits 3..2 ignored
          kind_latched_next      = KIND_LONG;
          flags_latched_next     = b[1:0];
          length_bytes_left_next = 2'd3;
          phase_next             = PH_LEN;
          role                   = ROLE_HEADER;
        end else begin
          kind_latched_next  = KIND_CTRL;
          flags_latched_next = 2'b00;
          role               = ROLE_CTRL;
          atom_end           = 1'b1;
        end
      end
    endcase

    // Length complete: fix status, start payload or end an empty atom
    if (hdr_done) begin
      status_latched_next = hdr_status(flags_latched_next, length_latched_next,
                                       bytes_limit);
      payload_left_next   = length_latched_next;
      if (length_latched_next == 24'd0) begin
        phase_next = PH_HEADER;
        atom_end   = 1'b1;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    res_next.role        = role;
    res_next.atom_kind   = kind_latched_next;
    res_next.is_bytes    = flags_latched_next[1];
    res_next.is_signed   = flags_latched_next[0];
    res_next.atom_length = length_latched_next;
    res_next.byte_out    = b;
    res_next.int_value   = value_accum_next;
    res_next.atom_end    = atom_end;
    res_next.status      = status_latched_next;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_limit <= BYTES_LIMIT_RESET;
    end else if (cfg_we) begin
      bytes_limit <= cfg_data;
    end
  end

  // Input register: load on accept, hold while the decode stage stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item <= in_ch.data;
    end
  end

  // Atom state and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid         <= 1'b0;
      phase             <= PH_HEADER;
      length_bytes_left <= 2'd0;
      payload_left      <= 24'd0;
      length_latched    <= 24'd0;
      kind_latched      <= KIND_TINY;
      flags_latched     <= 2'b00;
      value_accum       <= 64'd0;
      status_latched    <= STAT_OK;
    end else begin
      if (res_free) begin
        res_valid <= in_valid;
      end
      if (advance) begin
        phase             <= phase_next;
        length_bytes_left <= length_bytes_left_next;
        payload_left      <= payload_left_next;
        length_latched    <= length_latched_next;
        kind_latched      <= kind_latched_next;
        flags_latched     <= flags_latched_next;
        value_accum       <= value_accum_next;
        status_latched    <= status_latched_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  // Result word classes seen by the checks below
  logic res_len_word;    // a length byte is waiting at the output
  logic res_multi_len;   // the waiting word belongs to a medium or long atom
  logic res_one_byte;    // a tiny atom or a control token is waiting

  assign res_len_word  = res_valid && res.role == ROLE_LEN;
  assign res_multi_len = res.atom_kind == KIND_MEDIUM || res.atom_kind == KIND_LONG;
  assign res_one_byte  = res_valid && (res.role == ROLE_TINY || res.role == ROLE_CTRL);

  // Length phase always has length bytes outstanding
  `TASD_ASSERT_IMPLY(a_len_pending, clk, rst, phase == PH_LEN, length_bytes_left != 2'd0)

  // Payload phase always has payload bytes outstanding
  `TASD_ASSERT_IMPLY(a_pay_pending, clk, rst, phase == PH_PAYLOAD, payload_left != 24'd0)

  // Length bytes belong only to medium and long atoms
  `TASD_ASSERT_IMPLY(a_len_kind, clk, rst, res_len_word, res_multi_len)

  // Tiny atoms and control tokens never carry a status and always end their atom
  `TASD_ASSERT_IMPLY(a_status_role, clk, rst, res_one_byte, res.status == STAT_OK && res.atom_end)

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Token atom stream decoder testbench
// Feeds directed and random token byte streams through the decoder under
// random sender gaps, receiver stalls and one long output hold-off. A local
// decoder model predicts every result word not typed in by a directed row, and
// the results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tasd_pkg::*;

  // Decoder model phases: header expected, length bytes, payload bytes
  typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_PAYLOAD} dec_phase_e;

  // One directed stimulus row; a pinned row carries its result typed in
  typedef struct {
    in_item_t  word;
    bit        pinned;
    out_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [23:0] cfg_data;

  tasd_in_if  in_ch ();
  tasd_out_if out_ch ();

  token_atom_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model state, a private copy of what the decoder keeps per atom
  dec_phase_e  st_phase    = PH_HEADER;
  logic [1:0]  len_left    = '0;
  logic [23:0] pay_left    = '0;
  logic [23:0] len_acc     = '0;
  logic [2:0]  st_kind     = KIND_TINY;
  logic        flag_b      = 1'b0;
  logic        flag_s      = 1'b0;
  logic [63:0] value_acc   = '0;
  logic [1:0]  st_status   = STAT_OK;
  logic [23:0] bytes_limit = BYTES_LIMIT_RESET;

  out_item_t   pending_results[$];  // predicted words not yet seen at the output
  in_item_t    atom_bytes[$];       // random stream bytes waiting to be sent
  stim_row_t   stim_rows[$];
  bit          restart_next = 1'b0; // abort the atom in progress with the next header
  int          mismatches   = 0;
  int          tx_idle_pct  = 24;
  int          rx_idle_pct  = 55;
  int          rx_hold_len  = 0;    // length of the next receiver hold-off
  int          rx_hold_req  = 0;    // bumped to hand a new hold-off to the receiver
  int          rx_hold_seen = 0;    // last request the receiver picked up
  int          rx_stall_left = 0;

  // Length is complete: fix the status and open the payload.
  // Return 1 when the atom ends right here (zero length).
  function automatic logic length_complete();
    if (flag_b) begin
      if (flag_s) st_status = STAT_CONTINUED;  // continued beats over limit
      else if (len_acc > bytes_limit) st_status = STAT_OVER;
      else st_status = STAT_OK;
    end else begin
      st_status = (len_acc > INT_MAX_BYTES) ? STAT_INT_LONG : STAT_OK;
    end
    pay_left = len_acc;
    if (len_acc == '0) begin
      st_phase = PH_HEADER;
      return 1'b1;
    end
    st_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // Advance the model by one stream byte and return the word it should produce
  function automatic out_item_t decode_byte(input in_item_t w);
    out_item_t  r;
    logic [7:0] b;
    logic       ends;
    b    = w.data_byte;
    r    = '0;
    ends = 1'b0;
    // A restart drops whatever atom is open, with no status
    if (w.restart) st_phase = PH_HEADER;
    case (st_phase)
      PH_HEADER: begin
        value_acc = '0;
        st_status = STAT_OK;
        len_acc   = '0;
        len_left  = '0;
        pay_left  = '0;
        if ((b & HDR_TINY_MASK) == 8'h00) begin
          st_kind   = KIND_TINY;
          flag_b    = 1'b0;
          flag_s    = b[6];
          value_acc = {58'd0, b[5:0]};
          r.role    = ROLE_TINY;
          ends      = 1'b1;
        end else if ((b & HDR_SHORT_MASK) == HDR_SHORT_PAT) begin
          st_kind = KIND_SHORT;
          flag_b  = b[5];
          flag_s  = b[4];
          len_acc = {20'd0, b[3:0]};
          r.role  = ROLE_HEADER;
          ends    = length_complete();
        end else if ((b & HDR_MED_MASK) == HDR_MED_PAT) begin
          st_kind  = KIND_MEDIUM;
          flag_b   = b[4];
          flag_s   = b[3];
          len_acc  = {21'd0, b[2:0]};
          len_left = 2'd1;
          st_phase = PH_LENGTH;
          r.role   = ROLE_HEADER;
        end else if ((b & HDR_LONG_MASK) == HDR_LONG_PAT) begin
          // bits 3..2 of a long header are reserved and ignored
          st_kind  = KIND_LONG;
          flag_b   = b[1];
          flag_s   = b[0];
          len_left = 2'd3;
          st_phase = PH_LENGTH;
          r.role   = ROLE_HEADER;
        end else begin
          st_kind = KIND_CTRL;
          flag_b  = 1'b0;
          flag_s  = 1'b0;
          r.role  = ROLE_CTRL;
          ends    = 1'b1;
        end
      end
      PH_LENGTH: begin
        r.role  = ROLE_LEN;
        len_acc = {len_acc[15:0], b};
        if (len_left != '0) len_left = len_left - 2'd1;
        if (len_left == '0) ends = length_complete();
      end
      default: begin
        r.role = ROLE_PAYLOAD;
        if (pay_left != '0) pay_left = pay_left - 24'd1;
        // integers keep the low 64 bits of the big-endian value
        if (!flag_b) value_acc = {value_acc[55:0], b};
        if (pay_left == '0) begin
          ends     = 1'b1;
          st_phase = PH_HEADER;
        end
      end
    endcase
    r.atom_kind   = st_kind;
    r.is_bytes    = flag_b;
    r.is_signed   = flag_s;
    r.atom_length = len_acc;
    r.byte_out    = b;
    r.int_value   = value_acc;
    r.atom_end    = ends;
    r.status      = st_status;
    return r;
  endfunction

  function automatic out_item_t result_of(input logic [2:0] r_role, input logic [2:0] r_kind,
                                          input logic r_b, input logic r_s,
                                          input logic [23:0] r_len, input logic [7:0] r_byte,
                                          input logic [63:0] r_val, input logic r_end,
                                          input logic [1:0] r_stat);
    out_item_t r;
    r.role        = r_role;
    r.atom_kind   = r_kind;
    r.is_bytes    = r_b;
    r.is_signed   = r_s;
    r.atom_length = r_len;
    r.byte_out    = r_byte;
    r.int_value   = r_val;
    r.atom_end    = r_end;
    r.status      = r_stat;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [7:0] b, input logic rs,
                                    input bit pin = 1'b0, input out_item_t want = '0);
    stim_row_t s;
    s.word.data_byte = b;
    s.word.restart   = rs;
    s.pinned         = pin;
    s.want           = want;
    return s;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic rs);
    in_item_t w;
    w.data_byte = b;
    w.restart   = rs;
    atom_bytes.push_back(w);
  endfunction

  // Append one random atom to the stream. Most are well formed with random
  // content; some are cut short by a restart, some are plain noise.
  function automatic void queue_atom();
    int         sel;
    int         len;
    int         n_pay;
    logic [1:0] fl;
    logic       rs;
    sel = $urandom_range(99);
    fl  = 2'($urandom);
    len = 0;
    rs  = restart_next || ($urandom_range(24) == 0);
    restart_next = 1'b0;
    if (sel < 14) begin
      queue_byte({1'b0, 7'($urandom)}, rs);
      return;
    end else if (sel < 24) begin
      queue_byte({4'hF, 4'($urandom)}, rs);
      return;
    end else if (sel < 30) begin
      // noise: any byte, any restart
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'($urandom));
      return;
    end else if (sel < 55) begin
      len = $urandom_range(15);
      queue_byte({2'b10, fl, len[3:0]}, rs);
    end else if (sel < 80) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(24);
      queue_byte({3'b110, fl, len[10:8]}, rs);
      queue_byte(len[7:0], 1'b0);
    end else begin
      len = ($urandom_range(5) == 0) ? $urandom_range(24'hFFFFFF) : $urandom_range(40);
      queue_byte({4'b1110, 2'($urandom), fl}, rs);
      queue_byte(len[23:16], 1'b0);
      queue_byte(len[15:8], 1'b0);
      queue_byte(len[7:0], 1'b0);
    end
    // cut big atoms short, and now and then a small one
    if (len > 48) n_pay = $urandom_range(8);
    else if (len != 0 && $urandom_range(19) == 0) n_pay = $urandom_range(len - 1);
    else n_pay = len;
    if (n_pay != len) restart_next = 1'b1;
    repeat (n_pay) queue_byte(8'($urandom), 1'b0);
  endfunction

  // Offer one word, hold it until accepted, then predict its result.
  // Enter and leave on a falling edge.
  task automatic push_word(input in_item_t w, input bit pin = 1'b0,
                           input out_item_t want = '0);
    out_item_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = decode_byte(w);
    pending_results.push_back(pin ? want : got);
    @(negedge clk);
  endtask

  // Drop valid, wait out every expected word, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Reprogram the limit while idle, set the idling mix and send n random words
  task automatic run_phase(input logic [23:0] limit, input int tx_pct, input int rx_pct,
                           input int stall, input int n_words);
    int sent;
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= limit;
    @(negedge clk);
    cfg_we      <= 1'b0;
    bytes_limit = limit;
    // hand the receiver its settings away from its own edge
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    rx_hold_len = stall;
    rx_hold_req++;
    @(negedge clk);
    sent = 0;
    while (sent < n_words) begin
      if (atom_bytes.size() == 0) queue_atom();
      push_word(atom_bytes.pop_front());
      sent++;
    end
  endtask

  // Receiver: hold off for a counted stretch when asked, else stall at random
  always @(negedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen  = rx_hold_req;
      rx_stall_left = rx_hold_len;
    end
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void chk_field(input string fname, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatches++;
    end
  endfunction

  // Check every accepted result word against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: byte_out 0x%0h", got.byte_out);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        chk_field("role",        want.role,        got.role);
        chk_field("atom_kind",   want.atom_kind,   got.atom_kind);
        chk_field("is_bytes",    want.is_bytes,    got.is_bytes);
        chk_field("is_signed",   want.is_signed,   got.is_signed);
        chk_field("atom_length", want.atom_length, got.atom_length);
        chk_field("byte_out",    want.byte_out,    got.byte_out);
        chk_field("int_value",   want.int_value,   got.int_value);
        chk_field("atom_end",    want.atom_end,    got.atom_end);
        chk_field("status",      want.status,      got.status);
      end
    end
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("FAIL token_atom_stream_decoder");
    $finish;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    rst          = 1'b1;

    // Directed rows, run against the reset limit of 2048
    stim_rows.push_back(row(8'h00, 1'b0, 1'b1, result_of(ROLE_TINY, KIND_TINY, 1'b0, 1'b0,
                        24'd0, 8'h00, 64'd0, 1'b1, STAT_OK)));
    stim_rows.push_back(row(8'h7F, 1'b0, 1'b1, result_of(ROLE_TINY, KIND_TINY, 1'b0, 1'b1,
                        24'd0, 8'h7F, 64'h3F, 1'b1, STAT_OK)));
    stim_rows.push_back(row(8'hF0, 1'b0, 1'b1, result_of(ROLE_CTRL, KIND_CTRL, 1'b0, 1'b0,
                        24'd0, 8'hF0, 64'd0, 1'b1, STAT_OK)));
    stim_rows.push_back(row(8'hFF, 1'b0, 1'b1, result_of(ROLE_CTRL, KIND_CTRL, 1'b0, 1'b0,
                        24'd0, 8'hFF, 64'd0, 1'b1, STAT_OK)));
    // zero-length short atoms end on their header
    stim_rows.push_back(row(8'h80, 1'b0, 1'b1, result_of(ROLE_HEADER, KIND_SHORT, 1'b0, 1'b0,
                        24'd0, 8'h80, 64'd0, 1'b1, STAT_OK)));
    stim_rows.push_back(row(8'hB0, 1'b0, 1'b1, result_of(ROLE_HEADER, KIND_SHORT, 1'b1, 1'b1,
                        24'd0, 8'hB0, 64'd0, 1'b1, STAT_CONTINUED)));
    // zero-length medium atom ends on its length byte
    stim_rows.push_back(row(8'hC0, 1'b0, 1'b1, result_of(ROLE_HEADER, KIND_MEDIUM, 1'b0, 1'b0,
                        24'd0, 8'hC0, 64'd0, 1'b0, STAT_OK)));
    stim_rows.push_back(row(8'h00, 1'b0));
    // nine-byte integer: too long, low 64 bits kept
    stim_rows.push_back(row(8'h89, 1'b0, 1'b1, result_of(ROLE_HEADER, KIND_SHORT, 1'b0, 1'b0,
                        24'd9, 8'h89, 64'd0, 1'b0, STAT_INT_LONG)));
    stim_rows.push_back(row(8'hFF, 1'b0));
    stim_rows.push_back(row(8'h01, 1'b0));
    stim_rows.push_back(row(8'h23, 1'b0));
    stim_rows.push_back(row(8'h45, 1'b0));
    stim_rows.push_back(row(8'h67, 1'b0));
    stim_rows.push_back(row(8'h89, 1'b0));
    stim_rows.push_back(row(8'hAB, 1'b0));
    stim_rows.push_back(row(8'hCD, 1'b0));
    stim_rows.push_back(row(8'hEF, 1'b0, 1'b1, result_of(ROLE_PAYLOAD, KIND_SHORT, 1'b0, 1'b0,
                        24'd9, 8'hEF, 64'h0123456789ABCDEF, 1'b1, STAT_INT_LONG)));
    // continued byte atom at the largest length, also over the limit
    stim_rows.push_back(row(8'hE3, 1'b0));
    stim_rows.push_back(row(8'hFF, 1'b0));
    stim_rows.push_back(row(8'hFF, 1'b0));
    stim_rows.push_back(row(8'hFF, 1'b0, 1'b1, result_of(ROLE_LEN, KIND_LONG, 1'b1, 1'b1,
                        24'hFFFFFF, 8'hFF, 64'd0, 1'b0, STAT_CONTINUED)));
    // restart mid-atom into a long header with its reserved bits set
    stim_rows.push_back(row(8'hEE, 1'b1));
    stim_rows.push_back(row(8'h00, 1'b0));
    stim_rows.push_back(row(8'h08, 1'b0));
    stim_rows.push_back(row(8'h01, 1'b0, 1'b1, result_of(ROLE_LEN, KIND_LONG, 1'b1, 1'b0,
                        24'h000801, 8'h01, 64'd0, 1'b0, STAT_OVER)));
    // over-limit payload still flows, then abort it with a control token
    stim_rows.push_back(row(8'h5A, 1'b0));
    stim_rows.push_back(row(8'hFE, 1'b1, 1'b1, result_of(ROLE_CTRL, KIND_CTRL, 1'b0, 1'b0,
                        24'd0, 8'hFE, 64'd0, 1'b1, STAT_OK)));

    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) push_word(stim_rows[i].word, stim_rows[i].pinned, stim_rows[i].want);

    // Random words: limit at both extremes, then a small one that trips often.
    // The last phase opens with a long receiver hold-off so the decoder fills
    // and pushes back on the sender.
    run_phase(24'd0,                    24, 55, 0,   580);
    run_phase(24'hFFFFFF,               55, 24, 0,   580);
    run_phase(24'($urandom_range(1, 30)), 0, 0, 400, 590);

    drain();
    if (mismatches == 0) begin
      $display("PASS token_atom_stream_decoder");
    end else begin
      $display("FAIL token_atom_stream_decoder");
    end
    $finish;
  end

endmodule
